### rtl/core/calendar_to_epoch_seconds_assert.svh
`ifndef CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH
`define CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define C2E_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar_to_epoch_seconds: check failed");

// Next-cycle implication.
`define C2E_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar_to_epoch_seconds: check failed");

`endif

### rtl/core/c2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c2e_pkg;

  localparam logic [15:0] BASE_YEAR  = 16'd1970;
  // Leap years in 1 .. BASE_YEAR-1: 1969/4 - 1969/100 + 1969/400.
  localparam logic [8:0]  BASE_LEAPS = 9'd477;
  // ceil(2^19 / 25); exact quotient by 25 for any 14-bit dividend.
  localparam logic [16:0] RECIP25    = 17'd20972;

  typedef logic [3:0] step_t;

  localparam step_t STEP_FIRST = 4'd0;
  localparam step_t STEP_FAIL  = 4'd14;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_YQ4,
    MS_PQ4,
    MS_YSPAN,
    MS_ACC,
    MS_HOUR,
    MS_MIN
  } mul_sel_e;

  typedef enum logic [2:0] {
    KS_RECIP25,
    KS_365,
    KS_86400,
    KS_3600,
    KS_60
  } k_sel_e;

  typedef enum logic [2:0] {
    AO_NOP,
    AO_CLR,
    AO_ADD,
    AO_SUB,
    AO_LDT,
    AO_ADDT
  } acc_op_e;

  typedef enum logic [2:0] {
    AS_Q25,
    AS_Q100,
    AS_PQ4,
    AS_BASELEAP,
    AS_MDAYS,
    AS_DAYM1,
    AS_SEC
  } acc_sel_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    k_sel_e   k_sel;
    acc_op_e  acc_op;
    acc_sel_e acc_sel;
    logic     leap_en;
    logic     jmp_inv;
    step_t    jmp_tgt;
    logic     done;
    logic     fail;
  } uword_t;

  function automatic uword_t uw(mul_sel_e ms, k_sel_e ks, acc_op_e ao, acc_sel_e as,
                                logic leap_en, logic jmp_inv, logic done, logic fail);
    uword_t w;
    w.mul_sel = ms;
    w.k_sel   = ks;
    w.acc_op  = ao;
    w.acc_sel = as;
    w.leap_en = leap_en;
    w.jmp_inv = jmp_inv;
    w.jmp_tgt = STEP_FAIL;
    w.done    = done;
    w.fail    = fail;
    return w;
  endfunction

  // Microprogram. Step 1 resolves the leap flag and branches out on an invalid reading.
  function automatic uword_t ucode(step_t pc);
    uword_t w;
    case (pc)
      4'd0:  w = uw(MS_YQ4,   KS_RECIP25, AO_CLR,  AS_SEC,      1'b0, 1'b0, 1'b0, 1'b0);
      4'd1:  w = uw(MS_PQ4,   KS_RECIP25, AO_NOP,  AS_SEC,      1'b1, 1'b1, 1'b0, 1'b0);
      4'd2:  w = uw(MS_NONE,  KS_365,     AO_SUB,  AS_Q25,      1'b0, 1'b0, 1'b0, 1'b0);
      4'd3:  w = uw(MS_YSPAN, KS_365,     AO_ADD,  AS_Q100,     1'b0, 1'b0, 1'b0, 1'b0);
      4'd4:  w = uw(MS_NONE,  KS_365,     AO_ADDT, AS_SEC,      1'b0, 1'b0, 1'b0, 1'b0);
      4'd5:  w = uw(MS_NONE,  KS_365,     AO_ADD,  AS_PQ4,      1'b0, 1'b0, 1'b0, 1'b0);
      4'd6:  w = uw(MS_NONE,  KS_365,     AO_SUB,  AS_BASELEAP, 1'b0, 1'b0, 1'b0, 1'b0);
      4'd7:  w = uw(MS_NONE,  KS_365,     AO_ADD,  AS_MDAYS,    1'b0, 1'b0, 1'b0, 1'b0);
      4'd8:  w = uw(MS_NONE,  KS_365,     AO_ADD,  AS_DAYM1,    1'b0, 1'b0, 1'b0, 1'b0);
      4'd9:  w = uw(MS_ACC,   KS_86400,   AO_NOP,  AS_SEC,      1'b0, 1'b0, 1'b0, 1'b0);
      4'd10: w = uw(MS_HOUR,  KS_3600,    AO_LDT,  AS_SEC,      1'b0, 1'b0, 1'b0, 1'b0);
      4'd11: w = uw(MS_MIN,   KS_60,      AO_ADDT, AS_SEC,      1'b0, 1'b0, 1'b0, 1'b0);
      4'd12: w = uw(MS_NONE,  KS_60,      AO_ADDT, AS_SEC,      1'b0, 1'b0, 1'b0, 1'b0);
      4'd13: w = uw(MS_NONE,  KS_60,      AO_ADD,  AS_SEC,      1'b0, 1'b0, 1'b1, 1'b0);
      default: w = uw(MS_NONE, KS_60,     AO_NOP,  AS_SEC,      1'b0, 1'b0, 1'b1, 1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before this one, common year.
  function automatic logic [8:0] days_before(logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/core/calendar_to_epoch_seconds.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts one broken-down clock reading (year, month, day, hour, minute,
// second) into seconds since 1970-01-01 00:00:00 under Gregorian rules.
// Command channel: a beat is taken at the rising edge where start is high
// and busy is low; the six fields are sampled at that edge. Busy stays high
// until the conversion has finished.
// Result channel: done_o is high for exactly one cycle, with status_o and
// epoch_seconds_o valid in that cycle. The receiver cannot hold results off.
// A reading that is not a real date and time gives status 1 and seconds 0.
// Sequence: a valid reading runs the whole microprogram before done_o
// strobes, an invalid one branches to the failure step from step 1; the
// next beat can be accepted in the cycle of the strobe. The pace is set
// by the microprogram: one step per cycle over a single multiplier and
// a single 41-bit accumulator.
// Reset is asynchronous and active low; it clears busy, the step counter and
// the strobe. No result is pending after reset.
module calendar_to_epoch_seconds (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [15:0] year_i,
  input  wire logic [3:0]  month_i,
  input  wire logic [4:0]  day_i,
  input  wire logic [4:0]  hour_i,
  input  wire logic [5:0]  minute_i,
  input  wire logic [5:0]  second_i,
  output      logic        done_o,
  output      logic        status_o,
  output      logic [40:0] epoch_seconds_o
);

  // Control state.
  logic              busy_q;
  c2e_pkg::step_t    pc_q, pc_d;
  logic              done_q;

  // Latched reading.
  logic [15:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  // Datapath: product register, accumulator, leap flag, result registers.
  logic [40:0] tmp_q, tmp_d;
  logic [40:0] acc_q, acc_d;
  logic        leap_q;
  logic        status_q;
  logic [40:0] epoch_q;

  c2e_pkg::uword_t uw;
  logic            accept;

  logic [15:0] yspan;
  logic [15:0] ym1;
  logic [13:0] yq4;
  logic [13:0] pq4;
  logic [9:0]  q25;
  logic [13:0] q25x25;
  logic        leap_now;
  logic [4:0]  max_day;
  logic        invalid;
  logic [24:0] mul_a;
  logic [16:0] mul_k;
  logic [41:0] product;
  logic [40:0] acc_opnd;

  assign accept = start && !busy_q;
  assign uw     = c2e_pkg::ucode(pc_q);

  assign yspan = year_q - c2e_pkg::BASE_YEAR;
  assign ym1   = year_q - 16'd1;
  assign yq4   = year_q[15:2];
  assign pq4   = ym1[15:2];

  // The product register holds dividend * RECIP25; bits 28:19 are the quotient by 25.
  assign q25    = tmp_q[28:19];
  assign q25x25 = {q25, 4'b0000} + {1'b0, q25, 3'b000} + {4'b0000, q25};

  // Year = 4u. It is a century when u is a multiple of 25, and then a leap
  // year only when u / 25 is a multiple of 4. Valid only at step 1.
  assign leap_now = (year_q[1:0] == 2'b00) && ((yq4 != q25x25) || (q25[1:0] == 2'b00));

  always_comb begin
    max_day = c2e_pkg::month_len(month_q);
    if ((month_q == 4'd2) && leap_now) begin
      max_day = 5'd29;
    end
    invalid = (year_q < c2e_pkg::BASE_YEAR) || (month_q == 4'd0) || (month_q > 4'd12) ||
              (day_q == 5'd0) || (day_q > max_day) || (hour_q > 5'd23) ||
              (minute_q > 6'd59) || (second_q > 6'd59);
  end

  // Multiplier operands.
  always_comb begin
    case (uw.mul_sel)
      c2e_pkg::MS_YQ4:   mul_a = {11'd0, yq4};
      c2e_pkg::MS_PQ4:   mul_a = {11'd0, pq4};
      c2e_pkg::MS_YSPAN: mul_a = {9'd0, yspan};
      c2e_pkg::MS_ACC:   mul_a = acc_q[24:0];
      c2e_pkg::MS_HOUR:  mul_a = {20'd0, hour_q};
      c2e_pkg::MS_MIN:   mul_a = {19'd0, minute_q};
      default:           mul_a = 25'd0;
    endcase
    case (uw.k_sel)
      c2e_pkg::KS_RECIP25: mul_k = c2e_pkg::RECIP25;
      c2e_pkg::KS_365:     mul_k = 17'd365;
      c2e_pkg::KS_86400:   mul_k = 17'd86400;
      c2e_pkg::KS_3600:    mul_k = 17'd3600;
      default:             mul_k = 17'd60;
    endcase
    product = mul_a * mul_k;
    tmp_d   = (uw.mul_sel == c2e_pkg::MS_NONE) ? tmp_q : product[40:0];
  end

  // Accumulator. Intermediate day counts may wrap below zero; the final
  // count is positive, so modular arithmetic gives the exact value.
  always_comb begin
    case (uw.acc_sel)
      c2e_pkg::AS_Q25:      acc_opnd = {31'd0, q25};
      c2e_pkg::AS_Q100:     acc_opnd = {33'd0, q25[9:2]};
      c2e_pkg::AS_PQ4:      acc_opnd = {27'd0, pq4};
      c2e_pkg::AS_BASELEAP: acc_opnd = {32'd0, c2e_pkg::BASE_LEAPS};
      c2e_pkg::AS_MDAYS:    acc_opnd = {32'd0, c2e_pkg::days_before(month_q)} +
                                       {40'd0, leap_q && (month_q > 4'd2)};
      c2e_pkg::AS_DAYM1:    acc_opnd = {36'd0, day_q - 5'd1};
      default:              acc_opnd = {35'd0, second_q};
    endcase
    case (uw.acc_op)
      c2e_pkg::AO_CLR:  acc_d = 41'd0;
      c2e_pkg::AO_ADD:  acc_d = acc_q + acc_opnd;
      c2e_pkg::AO_SUB:  acc_d = acc_q - acc_opnd;
      c2e_pkg::AO_LDT:  acc_d = tmp_q;
      c2e_pkg::AO_ADDT: acc_d = acc_q + tmp_q;
      default:          acc_d = acc_q;
    endcase
  end

  // Step counter with the conditional branch to the failure step.
  always_comb begin
    if (uw.jmp_inv && invalid) begin
      pc_d = uw.jmp_tgt;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= c2e_pkg::STEP_FIRST;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (accept) begin
        busy_q <= 1'b1;
        pc_q   <= c2e_pkg::STEP_FIRST;
      end else if (busy_q) begin
        pc_q <= pc_d;
        if (uw.done) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      year_q   <= year_i;
      month_q  <= month_i;
      day_q    <= day_i;
      hour_q   <= hour_i;
      minute_q <= minute_i;
      second_q <= second_i;
    end
    if (busy_q) begin
      tmp_q <= tmp_d;
      acc_q <= acc_d;
      if (uw.leap_en) begin
        leap_q <= leap_now;
      end
      if (uw.done) begin
        status_q <= uw.fail;
        epoch_q  <= uw.fail ? 41'd0 : acc_d;
      end
    end
  end

  assign busy            = busy_q;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign epoch_seconds_o = epoch_q;

`include "calendar_to_epoch_seconds_assert.svh"

  // The strobe only follows the end of a program, never mid-run.
  `C2E_ASSERT_NOW(a_done_not_busy, done_o, !busy)
  // A failed conversion reports zero seconds.
  `C2E_ASSERT_NOW(a_fail_zero, done_o && status_o, epoch_seconds_o == 41'd0)
  // An accepted beat starts the sequencer at its first step.
  `C2E_ASSERT_NEXT(a_accept_runs, start && !busy, busy && (pc_q == c2e_pkg::STEP_FIRST))
  // Every program is at least two steps long, so strobes never touch.
  `C2E_ASSERT_NEXT(a_single_strobe, done_o, !done_o)

endmodule

`default_nettype wire
